### hdl/mfs_pkg.sv
// Shared types, codes and constants for the maximum-frequency stack.
package mfs_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DATA_W       = 32;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2,
		ST_RSVD       = 2'd3
	} status_t;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] push_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
	} out_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              push;
		logic              mark;
		logic              commit;
		logic [DATA_W-1:0] key;
	} bc_t;

endpackage

### hdl/mfs_cell.sv
// One storage cell of the stack chain: value, level, top-of-value flag.
module mfs_cell #(
	parameter int LVL_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mfs_pkg::bc_t              bc,
	input  logic [LVL_W-1:0]          max_level,
	input  logic [LVL_W-1:0]          new_level,
	input  logic                      below_valid,
	input  logic                      shift_in,
	input  logic                      cand_above,
	input  logic                      up_valid,
	input  logic                      up_top,
	input  logic [mfs_pkg::DATA_W-1:0] up_value,
	input  logic [LVL_W-1:0]          up_level,
	output logic                      valid,
	output logic                      top_fixed,
	output logic [mfs_pkg::DATA_W-1:0] value,
	output logic [LVL_W-1:0]          level,
	output logic                      cand_out,
	output logic                      shift_out,
	output logic [LVL_W-1:0]          hit_level,
	output logic [mfs_pkg::DATA_W-1:0] sel_value,
	output logic                      keep_max
);

	logic                       valid_q;
	logic                       top_q;
	logic                       mark_q;
	logic [mfs_pkg::DATA_W-1:0] value_q;
	logic [LVL_W-1:0]           level_q;
	logic                       key_hit;
	logic                       cand;
	logic                       sel;

	assign key_hit   = valid_q && (value_q == bc.key);
	assign cand      = valid_q && (level_q == max_level);
	// last candidate in push order wins a tie
	assign sel       = cand && !cand_above;
	assign cand_out  = cand || cand_above;
	assign shift_out = mark_q || shift_in;
	assign hit_level = (key_hit && top_q) ? level_q : '0;
	assign sel_value = sel ? value_q : '0;
	assign keep_max  = cand && !mark_q;
	// the next-lower copy of the popped value becomes its new top
	assign top_fixed = top_q || (key_hit && (level_q == max_level - LVL_W'(1)));

	assign valid = valid_q;
	assign value = value_q;
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			top_q   <= 1'b0;
			mark_q  <= 1'b0;
		end else if (bc.push) begin
			if (valid_q) begin
				if (key_hit && top_q)
					top_q <= 1'b0;
			end else if (below_valid) begin
				valid_q <= 1'b1;
				top_q   <= 1'b1;
			end
		end else if (bc.mark) begin
			mark_q <= sel;
		end else if (bc.commit) begin
			mark_q <= 1'b0;
			if (shift_out) begin
				valid_q <= up_valid;
				top_q   <= up_top;
			end else begin
				top_q <= top_fixed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bc.push && !valid_q && below_valid) begin
			value_q <= bc.key;
			level_q <= new_level;
		end else if (bc.commit && shift_out) begin
			value_q <= up_value;
			level_q <= up_level;
		end
	end

endmodule

### hdl/max_frequency_stack.sv
// Maximum-frequency stack: push values, pop the latest of the most frequent.
// Push: the result register is loaded at acceptance; a new item can be taken straight after.
// Pop: select, then close-up shift in the pop state; no new item is taken until the shift is done.
// Pop selection and close-up shift ripple across the cell chain, CAPACITY cells long.
// Asynchronous active-low reset empties the store; no clearing pass is needed.
// A result waiting in the output register blocks the next item until taken.
module max_frequency_stack #(
	parameter int CAPACITY = mfs_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mfs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mfs_pkg::out_t out_data
);

	localparam int LVL_W = $clog2(CAPACITY + 1);
	localparam int DW    = mfs_pkg::DATA_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} state_t;

	state_t            state_q;
	logic [LVL_W-1:0]  count_q;
	logic [LVL_W-1:0]  max_q;
	logic [DW-1:0]     pv_q;
	logic              out_valid_q;
	mfs_pkg::out_t     out_q;

	mfs_pkg::bc_t      bc;
	logic              accept;
	logic              is_push;
	logic              full;
	logic              empty;
	logic [LVL_W-1:0]  new_level;
	logic [LVL_W-1:0]  hit_or;
	logic [DW-1:0]     sel_or;
	logic              any_max;

	logic [CAPACITY-1:0]  c_valid;
	logic [CAPACITY-1:0]  c_top;
	logic [DW-1:0]        c_value [CAPACITY];
	logic [LVL_W-1:0]     c_level [CAPACITY];
	logic [LVL_W-1:0]     c_hit   [CAPACITY];
	logic [DW-1:0]        c_sel   [CAPACITY];
	logic [CAPACITY-1:0]  c_keep;
	logic [CAPACITY:0]    cand_chain;
	logic [CAPACITY:0]    shift_chain;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_push  = (in_data.cmd == mfs_pkg::CMD_PUSH);
	assign full     = (count_q == LVL_W'(CAPACITY));
	assign empty    = (count_q == '0);

	always_comb begin
		bc        = '0;
		bc.push   = accept && is_push && !full;
		bc.mark   = accept && !is_push && !empty;
		bc.commit = (state_q == S_POP);
		bc.key    = (state_q == S_POP) ? pv_q : in_data.push_value;
	end

	// at most one cell is the top copy of a given value
	always_comb begin
		hit_or  = '0;
		sel_or  = '0;
		any_max = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_or  = hit_or | c_hit[i];
			sel_or  = sel_or | c_sel[i];
			any_max = any_max | c_keep[i];
		end
	end

	assign new_level = hit_or + LVL_W'(1);

	assign cand_chain[CAPACITY] = 1'b0;
	assign shift_chain[0]       = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic             up_valid;
		logic             up_top;
		logic [DW-1:0]    up_value;
		logic [LVL_W-1:0] up_level;
		logic             below_valid;

		if (g == CAPACITY - 1) begin : g_last
			assign up_valid = 1'b0;
			assign up_top   = 1'b0;
			assign up_value = '0;
			assign up_level = '0;
		end else begin : g_mid
			assign up_valid = c_valid[g+1];
			assign up_top   = c_top[g+1];
			assign up_value = c_value[g+1];
			assign up_level = c_level[g+1];
		end

		if (g == 0) begin : g_first
			assign below_valid = 1'b1;
		end else begin : g_rest
			assign below_valid = c_valid[g-1];
		end

		mfs_cell #(
			.LVL_W(LVL_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bc         (bc),
			.max_level  (max_q),
			.new_level  (new_level),
			.below_valid(below_valid),
			.shift_in   (shift_chain[g]),
			.cand_above (cand_chain[g+1]),
			.up_valid   (up_valid),
			.up_top     (up_top),
			.up_value   (up_value),
			.up_level   (up_level),
			.valid      (c_valid[g]),
			.top_fixed  (c_top[g]),
			.value      (c_value[g]),
			.level      (c_level[g]),
			.cand_out   (cand_chain[g]),
			.shift_out  (shift_chain[g+1]),
			.hit_level  (c_hit[g]),
			.sel_value  (c_sel[g]),
			.keep_max   (c_keep[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_push) begin
							out_valid_q <= 1'b1;
							if (!full) begin
								count_q <= count_q + LVL_W'(1);
								if (new_level > max_q)
									max_q <= new_level;
							end
						end else if (empty) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					out_valid_q <= 1'b1;
					count_q     <= count_q - LVL_W'(1);
					if (!any_max)
						max_q <= max_q - LVL_W'(1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bc.mark)
			pv_q <= sel_or;
		if (state_q == S_POP) begin
			out_q.popped_value <= pv_q;
			out_q.status       <= mfs_pkg::ST_OK;
		end else if (accept) begin
			out_q.popped_value <= '0;
			if (is_push)
				out_q.status <= full ? mfs_pkg::ST_PUSH_FULL : mfs_pkg::ST_OK;
			else
				out_q.status <= empty ? mfs_pkg::ST_POP_EMPTY : mfs_pkg::ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/mfs_checker.sv
// Port-level checks for the maximum-frequency stack, bound to the top level.
module mfs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input mfs_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input mfs_pkg::out_t out_data
);

	// a held result holds its item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// a stalled result blocks intake
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted over a stalled result");

	// a push returns its result next cycle, with no value
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.cmd == mfs_pkg::CMD_PUSH)
		|=> out_valid && (out_data.popped_value == '0)
		&& (out_data.status != mfs_pkg::ST_POP_EMPTY))
		else $error("bad push result");

	// a pop never reports a full store
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.cmd == mfs_pkg::CMD_POP)
		|=> (!out_valid || (out_data.status != mfs_pkg::ST_PUSH_FULL)))
		else $error("bad pop result");

endmodule

bind max_frequency_stack mfs_checker u_mfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

### bench/max_frequency_stack_tb.sv
// Self-checking testbench for the maximum-frequency stack.
`timescale 1ns / 1ps

module max_frequency_stack_tb;

	localparam int CAPACITY    = mfs_pkg::DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 36;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_ready;
	mfs_pkg::in_t  in_data   = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	mfs_pkg::out_t out_data;

	// predictor state: stored values and levels, oldest first
	logic [31:0]   held_vals[$];
	int unsigned   held_lvls[$];
	mfs_pkg::out_t pending_results[$];

	bit          idle_on      = 1'b1;
	int          rx_hold_left = 0;
	int          cycle_count  = 0;
	int          n_fail       = 0;
	int          n_checked    = 0;
	int          n_push_ok    = 0;
	int          n_push_full  = 0;
	int          n_pop_ok     = 0;
	int          n_pop_empty  = 0;
	int unsigned top_level    = 0;
	int          deepest      = 0;

	max_frequency_stack #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #10 clk = ~clk;

	function automatic mfs_pkg::out_t apply_stack_cmd(mfs_pkg::cmd_t c, logic [31:0] v);
		mfs_pkg::out_t r;
		int unsigned   copies;
		int            best;
		r = '0;
		r.status = mfs_pkg::ST_OK;
		if (c == mfs_pkg::CMD_PUSH) begin
			if (held_vals.size() >= CAPACITY) begin
				r.status = mfs_pkg::ST_PUSH_FULL;
				n_push_full++;
			end else begin
				copies = 0;
				foreach (held_vals[i])
					if (held_vals[i] == v)
						copies++;
				held_vals.insert(held_vals.size(), v);
				held_lvls.insert(held_lvls.size(), copies + 1);
				if (copies + 1 > top_level)
					top_level = copies + 1;
				if (held_vals.size() > deepest)
					deepest = held_vals.size();
				n_push_ok++;
			end
		end else begin
			if (held_vals.size() == 0) begin
				r.status = mfs_pkg::ST_POP_EMPTY;
				n_pop_empty++;
			end else begin
				// ties go to the later entry
				best = 0;
				for (int i = 1; i < held_vals.size(); i++)
					if (held_lvls[i] >= held_lvls[best])
						best = i;
				r.popped_value = held_vals[best];
				held_vals.delete(best);
				held_lvls.delete(best);
				n_pop_ok++;
			end
		end
		return r;
	endfunction

	task automatic flag_error(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// One item on the input channel; prediction is made at acceptance.
	task automatic send_cmd(mfs_pkg::cmd_t c, logic [31:0] v);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{cmd: c, push_value: v};
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.insert(pending_results.size(), apply_stack_cmd(c, v));
	endtask

	// Mostly a small pool so that levels climb, sometimes anything at all.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 32'($signed($urandom_range(7)) - 4);
			5:             return {$urandom_range(1) ? 4'hF : 4'h8, 25'd0, 3'($urandom_range(7))};
			6:             return 32'h8000_0000;
			7:             return 32'h7FFF_FFFF;
			default:       return $urandom;
		endcase
	endfunction

	function automatic mfs_pkg::cmd_t pick_cmd(int push_pct);
		return ($urandom_range(99) < push_pct) ? mfs_pkg::CMD_PUSH : mfs_pkg::CMD_POP;
	endfunction

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (idle_on)
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		mfs_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (pending_results.size() == 0)
				flag_error($sformatf("result with nothing expected: value %h status %0d",
					out_data.popped_value, out_data.status));
			else begin
				want = pending_results.pop_front();
				if (out_data.popped_value !== want.popped_value)
					flag_error($sformatf("popped_value exp %h got %h",
						want.popped_value, out_data.popped_value));
				if (out_data.status !== want.status)
					flag_error($sformatf("status exp %0d got %0d",
						want.status, out_data.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Empty pop, field extremes, rising levels, ties and the pop order.
	task automatic test_directed();
		send_cmd(mfs_pkg::CMD_POP, 32'h0);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h8000_0000);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h0000_0000);
		send_cmd(mfs_pkg::CMD_PUSH, 32'hFFFF_FFFF);
		send_cmd(mfs_pkg::CMD_PUSH, 32'hAAAA_AAAA);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h5555_5555);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h8000_0000);
		send_cmd(mfs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_cmd(mfs_pkg::CMD_POP, 32'hFFFF_FFFF);  // value ignored on pop
		send_cmd(mfs_pkg::CMD_POP, 32'h0);
		send_cmd(mfs_pkg::CMD_POP, 32'h0);          // 7FFF_FFFF now stands alone at level two
		send_cmd(mfs_pkg::CMD_PUSH, 32'h0000_0000);
		send_cmd(mfs_pkg::CMD_POP, 32'h0);
		for (int i = 0; i < 7; i++)
			send_cmd(mfs_pkg::CMD_POP, 32'h0);
		send_cmd(mfs_pkg::CMD_POP, 32'h1234_5678);  // empty again
	endtask

	// Fill to capacity, push on full, drain past empty.
	task automatic test_fill_and_drain();
		while (held_vals.size() < CAPACITY)
			send_cmd(mfs_pkg::CMD_PUSH, pick_value());
		for (int i = 0; i < 3; i++)
			send_cmd(mfs_pkg::CMD_PUSH, pick_value());
		while (held_vals.size() > 0)
			send_cmd(mfs_pkg::CMD_POP, pick_value());
		send_cmd(mfs_pkg::CMD_POP, pick_value());
		send_cmd(mfs_pkg::CMD_POP, pick_value());
	endtask

	// Phases with different push bias so that the depth roams its range.
	task automatic test_random_mix();
		int bias[8] = '{80, 30, 95, 50, 10, 85, 55, 40};
		foreach (bias[p])
			for (int i = 0; i < 90; i++)
				send_cmd(pick_cmd(bias[p]), pick_value());
	endtask

	// Receiver holds off while the sender keeps offering items.
	task automatic test_output_stall();
		rx_hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_cmd(pick_cmd(60), pick_value());
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 150; i++)
			send_cmd(pick_cmd(i < 90 ? 75 : 35), pick_value());
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_output_stall();
		test_random_mix();
		test_back_to_back();
		test_fill_and_drain();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d results: %0d pushes, %0d full-store pushes, %0d pops, %0d empty pops",
			n_checked, n_push_ok, n_push_full, n_pop_ok, n_pop_empty);
		$display("Deepest store %0d of %0d, highest level %0d, %0d mismatches",
			deepest, CAPACITY, top_level, n_fail);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
